// ===== rtl/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// shared types, constants and the byte-wide crc-32 update for the record
// serialiser
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int unsigned BodyBytes  = 28;
  localparam int unsigned FrameBytes = 32;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned NumBanks   = 2;
  localparam int unsigned MemAddrW   = IdxW + 1;
  localparam int unsigned MemDepth   = NumBanks * (2 ** IdxW);

  localparam logic [31:0] CrcInit   = 32'hffff_ffff;
  localparam logic [31:0] CrcPoly   = 32'hedb8_8320;
  localparam logic [31:0] CrcXorOut = 32'hffff_ffff;

  localparam logic [IdxW-1:0] LastBodyIdx  = IdxW'(BodyBytes - 1);
  localparam logic [IdxW-1:0] LastFrameIdx = IdxW'(FrameBytes - 1);
  localparam logic [IdxW-1:0] BodyBytesIdx = IdxW'(BodyBytes);

  typedef struct packed {
    logic        [31:0] epoch_seconds;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [15:0] altitude;
    logic signed [15:0] pressure;
    logic        [15:0] speed;
    logic        [15:0] heading;
    logic        [7:0]  satellites;
    logic        [7:0]  dilution;
    logic        [7:0]  battery;
    logic signed [7:0]  temperature;
    logic        [31:0] flag_word;
  } record_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [IdxW-1:0] byte_index;
    logic            last_byte;
  } frame_byte_t;

  // memory write port, driven by the packer
  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [7:0]          data;
  } mem_wr_t;

  // memory read request, driven by the readout
  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
  } mem_rd_t;

  // hand-over of a filled bank from packer to readout
  typedef struct packed {
    logic        valid;
    logic        bank;
    logic [31:0] crc;
  } bank_done_t;

  // reflected crc-32, one byte folded in
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/rsc_rec_if.sv =====
// ----------------------------------------------------------------------------
// rsc_rec_if
// record channel: one telemetry record per word
// ----------------------------------------------------------------------------
interface rsc_rec_if;
  import rsc_pkg::*;

  logic    valid;
  logic    ready;
  record_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rsc_byte_if.sv =====
// ----------------------------------------------------------------------------
// rsc_byte_if
// frame channel: one frame byte with its position per word
// ----------------------------------------------------------------------------
interface rsc_byte_if;
  import rsc_pkg::*;

  logic        valid;
  logic        ready;
  frame_byte_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rsc_frame_mem.sv =====
// ----------------------------------------------------------------------------
// rsc_frame_mem
// two-bank frame body store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rsc_frame_mem (
  input  logic             clk_i,
  input  rsc_pkg::mem_wr_t wr_i,
  input  rsc_pkg::mem_rd_t rd_i,
  output logic [7:0]       rdata_o
);
  import rsc_pkg::*;

  logic [7:0] mem_q [MemDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rsc_packer.sv =====
// ----------------------------------------------------------------------------
// rsc_packer
// takes a record, writes its 28 body bytes into a free bank one per cycle
// and runs the crc alongside
// ----------------------------------------------------------------------------
module rsc_packer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rsc_rec_if.sink                  rec_i,
  input  logic [1:0]               bank_free_i,
  output rsc_pkg::mem_wr_t         wr_o,
  output rsc_pkg::bank_done_t      done_o
);
  import rsc_pkg::*;

  logic                  busy_q, busy_d;
  logic [IdxW-1:0]       cnt_q, cnt_d;
  logic                  bank_q, bank_d;
  logic [8*BodyBytes-1:0] body_q, body_d;
  logic [31:0]           crc_q, crc_d;
  logic [31:0]           crc_nx;
  logic                  accept;
  logic                  last;

  assign rec_i.ready = !busy_q && bank_free_i[bank_q];
  assign accept      = rec_i.valid && rec_i.ready;
  assign last        = (cnt_q == LastBodyIdx);
  assign crc_nx      = crc32_byte(crc_q, body_q[7:0]);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bank_d = bank_q;
    body_d = body_q;
    crc_d  = crc_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      crc_d  = CrcInit;
      // byte 0 of the frame sits in the low byte
      body_d = {rec_i.payload.flag_word,  rec_i.payload.temperature,
                rec_i.payload.battery,    rec_i.payload.dilution,
                rec_i.payload.satellites, rec_i.payload.heading,
                rec_i.payload.speed,      rec_i.payload.pressure,
                rec_i.payload.altitude,   rec_i.payload.longitude,
                rec_i.payload.latitude,   rec_i.payload.epoch_seconds};
    end else if (busy_q) begin
      body_d = body_q >> 8;
      crc_d  = crc_nx;
      cnt_d  = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        bank_d = !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q <= body_d;
    crc_q  <= crc_d;
  end

  assign wr_o.en   = busy_q;
  assign wr_o.addr = {bank_q, cnt_q};
  assign wr_o.data = body_q[7:0];

  assign done_o.valid = busy_q && last;
  assign done_o.bank  = bank_q;
  assign done_o.crc   = crc_nx ^ CrcXorOut;

endmodule

// ===== rtl/rsc_readout.sv =====
// ----------------------------------------------------------------------------
// rsc_readout
// streams a filled bank and its crc as 32 frame bytes, one per ready cycle
// ----------------------------------------------------------------------------
module rsc_readout (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsc_pkg::bank_done_t done_i,
  output logic [1:0]          bank_free_o,
  output rsc_pkg::mem_rd_t    rd_o,
  input  logic [7:0]          rdata_i,
  rsc_byte_if.source          frame_o
);
  import rsc_pkg::*;

  logic [1:0]      full_q, full_d;
  logic [31:0]     crc_q [NumBanks];
  logic            rd_bank_q, rd_bank_d;
  logic [IdxW-1:0] rd_cnt_q, rd_cnt_d;
  logic            s1_valid_q, s1_valid_d;
  logic [IdxW-1:0] s1_idx_q;
  logic            s1_bank_q;
  logic            out_valid_q, out_valid_d;
  frame_byte_t     out_q;
  logic            issue;
  logic            s1_adv;
  logic            s1_done;
  logic [31:0]     s1_crc;
  logic [7:0]      s1_byte;

  assign s1_adv  = s1_valid_q && (!out_valid_q || frame_o.ready);
  assign issue   = full_q[rd_bank_q] && (!s1_valid_q || s1_adv);
  assign s1_done = s1_adv && (s1_idx_q == LastFrameIdx);

  // crc bytes need no memory read
  assign rd_o.en   = issue && (rd_cnt_q < BodyBytesIdx);
  assign rd_o.addr = {rd_bank_q, rd_cnt_q};

  assign s1_crc  = crc_q[s1_bank_q];
  always_comb begin
    if (s1_idx_q < BodyBytesIdx) begin
      s1_byte = rdata_i;
    end else begin
      s1_byte = s1_crc[8*s1_idx_q[1:0] +: 8];
    end
  end

  always_comb begin
    rd_bank_d   = rd_bank_q;
    rd_cnt_d    = rd_cnt_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    full_d      = full_q;
    if (issue) begin
      s1_valid_d = 1'b1;
      rd_cnt_d   = rd_cnt_q + 1'b1;
      if (rd_cnt_q == LastFrameIdx) begin
        rd_bank_d = !rd_bank_q;
      end
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
    // bank is released only once its crc bytes have left the read stage
    if (s1_done) begin
      full_d[s1_bank_q] = 1'b0;
    end
    if (done_i.valid) begin
      full_d[done_i.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= '0;
      rd_bank_q   <= 1'b0;
      rd_cnt_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      full_q      <= full_d;
      rd_bank_q   <= rd_bank_d;
      rd_cnt_q    <= rd_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= rd_cnt_q;
      s1_bank_q <= rd_bank_q;
    end
    if (s1_adv) begin
      out_q.out_byte   <= s1_byte;
      out_q.byte_index <= s1_idx_q;
      out_q.last_byte  <= (s1_idx_q == LastFrameIdx);
    end
    if (done_i.valid) begin
      crc_q[done_i.bank] <= done_i.crc;
    end
  end

  assign bank_free_o     = ~full_q;
  assign frame_o.valid   = out_valid_q;
  assign frame_o.payload = out_q;

endmodule

// ===== rtl/record_serializer_crc32.sv =====
// ----------------------------------------------------------------------------
// record_serializer_crc32
// telemetry record to 32-byte little-endian frame with trailing crc-32
// ----------------------------------------------------------------------------
// Each record word on rec_i becomes 32 frame words on frame_o: the 28 body
// bytes (epoch, latitude, longitude, altitude, pressure, speed, heading,
// satellites, dilution, battery, temperature, flags, all little-endian, signed
// fields as raw two's complement) followed by the reflected crc-32 of the body
// (poly 0xedb88320, init and final xor all ones), low byte first. byte_index
// counts 0..31 and last_byte marks byte 31. The body sits in a two-bank byte
// memory: the packer writes one bank at one byte per cycle while the readout
// streams the other at one byte per cycle the sink is ready, so a new record
// can be taken while the last frame still streams; the readout's output word
// rate sets the steady-state record rate. The first frame byte waits for the
// whole body to be written and the bank handed over, then passes the read
// stage and output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module record_serializer_crc32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsc_rec_if.sink     rec_i,
  rsc_byte_if.source  frame_o
);
  import rsc_pkg::*;

  // packer -> memory write port, readout -> memory read port
  mem_wr_t    mem_wr;
  mem_rd_t    mem_rd;
  logic [7:0] mem_rdata;

  // bank hand-shaking: packer fills a free bank, readout frees it again
  // once the last crc byte has left its read stage; the two never touch
  // the same bank, so no forwarding is required
  bank_done_t bank_done;
  logic [1:0] bank_free;

  rsc_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_i),
    .bank_free_i (bank_free),
    .wr_o        (mem_wr),
    .done_o      (bank_done)
  );

  rsc_frame_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (mem_rdata)
  );

  // read stage plus output register, so a new byte moves each cycle the
  // sink is ready; a long stall fills both banks and then holds off the packer
  rsc_readout u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .done_i      (bank_done),
    .bank_free_o (bank_free),
    .rd_o        (mem_rd),
    .rdata_i     (mem_rdata),
    .frame_o     (frame_o)
  );

endmodule

// ===== test/record_serializer_crc32_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_serializer_crc32_tb
// drives telemetry records into the serialiser and checks every frame word
// ----------------------------------------------------------------------------
// A queue of records (a handful of hand-picked corner cases, then random ones)
// feeds a driver that offers them in bursts with random gaps. Each accepted
// record is packed little-endian and run through a bit-serial crc-32 here, and
// the 32 frame words it should produce wait in a queue. The monitor compares
// every accepted frame word with the oldest waiting one. The receiver stalls
// on its own rotating pattern and, once, holds off long enough to back the
// block up onto its record input.
// ----------------------------------------------------------------------------
module record_serializer_crc32_tb;
  import rsc_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned ResetCycles   = 7;
  localparam int unsigned RandomRecords = 450;
  localparam int unsigned HoldAfter     = 150;    // records taken before the long hold-off
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned DrainCycles   = 64;     // idle time after the last due word, to catch stray ones
  localparam int unsigned TimeoutCycles = 500_000;

  // receiver stall modes, taken in turn from the receiver's cycle count
  typedef enum logic [1:0] {
    RxFree,
    RxRandom,
    RxPeriodic,
    RxSparse
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsc_rec_if  record_ch ();
  rsc_byte_if frame_ch ();

  record_serializer_crc32 dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rec_i   (record_ch),
    .frame_o (frame_ch)
  );

  // records still to be offered, and frame words still owed by the block
  record_t     pending_records[$];
  frame_byte_t frame_bytes_due[$];

  int unsigned records_taken = 0;
  int unsigned total_records = 0;
  int unsigned mismatches    = 0;
  bit          record_fire   = 1'b0;  // record word accepted at the last rising edge

  // driver burst state
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // receiver state
  int unsigned rx_cycle  = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction: pack the body, fold it bit by bit into the crc, queue 32 words
  // --------------------------------------------------------------------------
  function automatic void build_frame(record_t rec);
    logic [8*BodyBytes-1:0] body;
    logic [31:0]            crc;
    logic                   feedback;
    frame_byte_t            word;
    // little-endian: the first field sits in the lowest bits, so byte k is body[8k +: 8]
    body = {rec.flag_word, rec.temperature, rec.battery, rec.dilution, rec.satellites,
            rec.heading, rec.speed, rec.pressure, rec.altitude,
            rec.longitude, rec.latitude, rec.epoch_seconds};
    // reflected crc, one message bit at a time, lsb of each byte first
    crc = CrcInit;
    for (int b = 0; b < 8 * BodyBytes; b++) begin
      feedback = crc[0] ^ body[b];
      crc      = (crc >> 1) ^ (feedback ? CrcPoly : 32'h0);
    end
    crc = crc ^ CrcXorOut;
    for (int k = 0; k < FrameBytes; k++) begin
      word.out_byte   = (k < BodyBytes) ? body[8*k +: 8] : crc[8*(k - BodyBytes) +: 8];
      word.byte_index = IdxW'(k);
      word.last_byte  = (k == FrameBytes - 1);
      frame_bytes_due.push_back(word);
    end
  endfunction

  // random field value, with the extremes for its width turning up often
  function automatic logic [31:0] field_value(int unsigned width);
    logic [31:0] sign_bit;
    logic [31:0] all_ones;
    sign_bit = 32'h1 << (width - 1);
    all_ones = (sign_bit << 1) - 32'h1;
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return all_ones;
      2:       return sign_bit;           // most negative when signed
      3:       return sign_bit - 32'h1;   // most positive when signed
      default: return $urandom() & all_ones;
    endcase
  endfunction

  function automatic record_t random_record();
    record_t rec;
    rec.epoch_seconds = field_value(32);
    rec.latitude      = field_value(32);
    rec.longitude     = field_value(32);
    rec.altitude      = 16'(field_value(16));
    rec.pressure      = 16'(field_value(16));
    rec.speed         = 16'(field_value(16));
    rec.heading       = 16'(field_value(16));
    rec.satellites    = 8'(field_value(8));
    rec.dilution      = 8'(field_value(8));
    rec.battery       = 8'(field_value(8));
    rec.temperature   = 8'(field_value(8));
    rec.flag_word     = field_value(32);
    return rec;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: record words in bursts, changed on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      record_ch.valid <= 1'b0;
    end else if (record_ch.valid && !record_fire) begin
      // word still on offer, keep it steady
    end else if (gap_left > 0) begin
      gap_left--;
      record_ch.valid <= 1'b0;
    end else if (pending_records.size() != 0) begin
      record_ch.valid   <= 1'b1;
      record_ch.payload <= pending_records.pop_front();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        // a third of the bursts run straight into the next one
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      end
    end else begin
      record_ch.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: rotating stall pattern, plus one long hold-off to fill the block
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rx_mode_e mode;
    if (!rst_ni) begin
      frame_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      mode = rx_mode_e'((rx_cycle >> 7) & 3);
      if (hold_left == 0 && !hold_done && records_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RxFree:     frame_ch.ready <= 1'b1;
          RxRandom:   frame_ch.ready <= ($urandom_range(0, 3) != 0);
          RxPeriodic: frame_ch.ready <= (rx_cycle % 5 != 2);
          RxSparse:   frame_ch.ready <= ($urandom_range(0, 4) < 2);
          default:    frame_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both channels sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    frame_byte_t seen;
    frame_byte_t want;
    record_fire = rst_ni && record_ch.valid && record_ch.ready;
    // queue the prediction first, so a word in the same cycle still finds it
    if (record_fire) begin
      build_frame(record_ch.payload);
      records_taken++;
    end
    if (rst_ni && frame_ch.valid && frame_ch.ready) begin
      seen = frame_ch.payload;
      if (frame_bytes_due.size() == 0) begin
        mismatches++;
        $error("frame word with none due: out_byte %0h byte_index %0d last_byte %0b",
               seen.out_byte, seen.byte_index, seen.last_byte);
      end else begin
        want = frame_bytes_due.pop_front();
        check_field("out_byte", want.out_byte, seen.out_byte);
        check_field("byte_index", 8'(want.byte_index), 8'(seen.byte_index));
        check_field("last_byte", 8'(want.last_byte), 8'(seen.last_byte));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    record_ch.valid   = 1'b0;
    record_ch.payload = '0;
    frame_ch.ready    = 1'b0;

    // all zeros, all ones (every signed field at minus one)
    pending_records.push_back('0);
    pending_records.push_back('1);
    // signed fields at their most positive, unsigned at full scale
    pending_records.push_back(record_t'{32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                        16'h7fff, 16'h7fff, 16'hffff, 16'hffff,
                                        8'hff, 8'hff, 8'hff, 8'h7f, 32'hffff_ffff});
    // signed fields at their most negative, unsigned at zero
    pending_records.push_back(record_t'{32'h0, 32'h8000_0000, 32'h8000_0000,
                                        16'h8000, 16'h8000, 16'h0, 16'h0,
                                        8'h0, 8'h0, 8'h0, 8'h80, 32'h0});
    // alternating bit patterns
    pending_records.push_back(record_t'{32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                        16'h5555, 16'h5555, 16'h5555, 16'h5555,
                                        8'h55, 8'h55, 8'h55, 8'h55, 32'h5555_5555});
    pending_records.push_back(record_t'{32'haaaa_aaaa, 32'haaaa_aaaa, 32'haaaa_aaaa,
                                        16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa,
                                        8'haa, 8'haa, 8'haa, 8'haa, 32'haaaa_aaaa});
    // byte k of the body carries k+1, so any misplaced byte shows
    pending_records.push_back(record_t'{32'h0403_0201, 32'h0807_0605, 32'h0c0b_0a09,
                                        16'h0e0d, 16'h100f, 16'h1211, 16'h1413,
                                        8'h15, 8'h16, 8'h17, 8'h18, 32'h1c1b_1a19});
    // mixed signs: negative latitude with positive longitude and the reverse
    pending_records.push_back(record_t'{32'h6543_2100, 32'hfe1d_c0a1, 32'h0123_4567,
                                        16'hff9c, 16'h03e8, 16'h0080, 16'h8000,
                                        8'h0c, 8'h01, 8'h64, 8'he7, 32'h8000_0001});
    pending_records.push_back(record_t'{32'h8000_0000, 32'h1234_5678, 32'hedcb_a987,
                                        16'h0064, 16'hfc18, 16'h8000, 16'h0080,
                                        8'h80, 8'hfe, 8'h01, 8'h19, 32'h0000_0001});
    // single bits set, walking across each field
    for (int s = 0; s < 8; s++) begin
      pending_records.push_back(record_t'{32'h1 << (4 * s), 32'h1 << (4 * s + 1),
                                          32'h1 << (4 * s + 2), 16'h1 << (2 * s),
                                          16'h1 << (2 * s + 1), 16'h2 << (2 * s),
                                          16'h8000 >> (2 * s), 8'h1 << s, 8'h80 >> s,
                                          8'h1 << s, 8'h80 >> s, 32'h8000_0000 >> (4 * s)});
    end

    repeat (RandomRecords) pending_records.push_back(random_record());
    total_records = pending_records.size();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (records_taken < total_records) @(posedge clk_i);
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
    // stray words after the last frame are still caught by the monitor
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("record_serializer_crc32_tb: done, clean");
    end else begin
      $display("record_serializer_crc32_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("record_serializer_crc32_tb: done, errors");
    $finish;
  end

endmodule
